// ----- rtl/bfc_pkg.sv -----
// Types and constants shared by the frame checksum checker.
// No dependencies.
package bfc_pkg;

    localparam int unsigned COUNT_W = 5;

    localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 5'd9;
    localparam logic [COUNT_W-1:0] TRAILER_LEN    = 5'd3;
    localparam logic [COUNT_W-1:0] LEN_BYTE_INDEX = 5'd1;
    localparam logic [15:0]        WORD_MASK      = 16'hFFFF;

    typedef struct packed {
        logic        check_ok;
        logic        swap_match;
        logic [15:0] computed_check;
        logic [15:0] received_check;
        logic [3:0]  data_length;
    } bfc_result_t;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        swap16 = {v[7:0], v[15:8]};
    endfunction

endpackage

// ----- rtl/bfc_byte_if.sv -----
// Byte channel into the frame checksum checker: valid/ready plus one frame byte.
// No dependencies.
interface bfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_start;

    modport source (output valid, output frame_byte, output frame_start, input ready);
    modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

// ----- rtl/bfc_result_if.sv -----
// Result channel out of the frame checksum checker: valid/ready plus check fields.
// No dependencies.
interface bfc_result_if;
    logic        valid;
    logic        ready;
    logic        check_ok;
    logic        swap_match;
    logic [15:0] computed_check;
    logic [15:0] received_check;
    logic [3:0]  data_length;

    modport source (
        output valid, output check_ok, output swap_match,
        output computed_check, output received_check, output data_length,
        input  ready
    );
    modport sink (
        input  valid, input check_ok, input swap_match,
        input  computed_check, input received_check, input data_length,
        output ready
    );
endinterface

// ----- rtl/bfc_frame_core.sv -----
// Frame state and ones' complement checksum datapath, one byte per step.
// Depends on bfc_pkg.
module bfc_frame_core
    import bfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        item_valid,
    input  logic [7:0]  frame_byte,
    input  logic        frame_start,
    output logic        emit,
    output bfc_result_t result
);

    logic               in_frame_reg, in_frame_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [3:0]         length_nibble_reg, length_nibble_next;
    logic [15:0]        running_sum_reg, running_sum_next;
    logic [7:0]         pending_low_reg, pending_low_next;
    logic [7:0]         received_low_reg, received_low_next;

    logic               active;
    logic [COUNT_W-1:0] k;
    logic [3:0]         len_cur;
    logic [3:0]         len_eff;
    logic [15:0]        sum_cur;
    logic [7:0]         pend_cur;
    logic [7:0]         rlow_cur;
    logic [COUNT_W-1:0] frame_len;
    logic [COUNT_W-1:0] last_data;
    logic [COUNT_W-1:0] trailer_lo;
    logic [COUNT_W-1:0] trailer_hi;
    logic [15:0]        add_word;
    logic [16:0]        raw_sum;
    logic [15:0]        folded_sum;
    logic [15:0]        comp;
    logic [15:0]        rec;
    logic               direct;
    logic               swapped;
    logic               is_last;

    always_comb
    begin
        if (frame_start)
        begin
            active   = item_valid;
            k        = '0;
            len_cur  = '0;
            sum_cur  = '0;
            pend_cur = '0;
            rlow_cur = '0;
        end
        else
        begin
            active   = item_valid && in_frame_reg;
            k        = byte_count_reg;
            len_cur  = length_nibble_reg;
            sum_cur  = running_sum_reg;
            pend_cur = pending_low_reg;
            rlow_cur = received_low_reg;
        end
    end

    assign len_eff    = (k == LEN_BYTE_INDEX) ? frame_byte[3:0] : len_cur;
    assign frame_len  = {1'b0, len_eff} + FRAME_OVERHEAD;
    assign trailer_lo = frame_len - TRAILER_LEN;
    assign last_data  = trailer_lo - COUNT_W'(1);
    assign trailer_hi = trailer_lo + COUNT_W'(1);

    assign add_word   = k[0] ? {frame_byte, pend_cur} : {8'h00, frame_byte};
    assign raw_sum    = {1'b0, sum_cur} + {1'b0, add_word};
    assign folded_sum = raw_sum[15:0] + {15'd0, raw_sum[16]};

    assign comp    = swap16((sum_cur ^ WORD_MASK) + 16'd1);
    assign rec     = {pend_cur, rlow_cur};
    assign direct  = (comp == rec);
    assign swapped = !direct && (comp == swap16(rec));

    assign is_last = (k > trailer_hi);
    assign emit    = active && is_last;

    always_comb
    begin
        result.check_ok       = direct || swapped;
        result.swap_match     = swapped;
        result.computed_check = comp;
        result.received_check = rec;
        result.data_length    = len_eff;
    end

    always_comb
    begin
        in_frame_next      = in_frame_reg;
        byte_count_next    = byte_count_reg;
        length_nibble_next = length_nibble_reg;
        running_sum_next   = running_sum_reg;
        pending_low_next   = pending_low_reg;
        received_low_next  = received_low_reg;
        if (step && active)
        begin
            if (is_last)
            begin
                in_frame_next      = 1'b0;
                byte_count_next    = '0;
                length_nibble_next = '0;
                running_sum_next   = '0;
                pending_low_next   = '0;
                received_low_next  = '0;
            end
            else
            begin
                in_frame_next      = 1'b1;
                byte_count_next    = k + COUNT_W'(1);
                length_nibble_next = len_eff;
                running_sum_next   = sum_cur;
                pending_low_next   = pend_cur;
                received_low_next  = rlow_cur;
                priority if (k <= last_data)
                begin
                    if (k[0] || (k == last_data))
                        running_sum_next = folded_sum;
                    else
                        pending_low_next = frame_byte;
                end
                else if (k == trailer_lo)
                    received_low_next = frame_byte;
                else
                    pending_low_next = frame_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg      <= 1'b0;
            byte_count_reg    <= '0;
            length_nibble_reg <= '0;
            running_sum_reg   <= '0;
            pending_low_reg   <= '0;
            received_low_reg  <= '0;
        end
        else
        begin
            in_frame_reg      <= in_frame_next;
            byte_count_reg    <= byte_count_next;
            length_nibble_reg <= length_nibble_next;
            running_sum_reg   <= running_sum_next;
            pending_low_reg   <= pending_low_next;
            received_low_reg  <= received_low_next;
        end
    end

endmodule

// ----- rtl/bfc_result_reg.sv -----
// Result register driving the result channel; holds a word until it is taken.
// Depends on bfc_pkg and bfc_result_if.
module bfc_result_reg
    import bfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  bfc_result_t  data,
    output logic         free,
    bfc_result_if.source result_out
);

    logic        valid_reg, valid_next;
    bfc_result_t data_reg;

    assign free = !valid_reg || result_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (result_out.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data;
    end

    assign result_out.valid          = valid_reg;
    assign result_out.check_ok       = data_reg.check_ok;
    assign result_out.swap_match     = data_reg.swap_match;
    assign result_out.computed_check = data_reg.computed_check;
    assign result_out.received_check = data_reg.received_check;
    assign result_out.data_length    = data_reg.data_length;

endmodule

// ----- rtl/bus_frame_checksum_checker.sv -----
// Bus frame checksum checker: one frame byte per word in, one check result per frame out.
// The last byte goes through the input register, its result into the result register.
// Throughput: one byte per cycle; the input register stalls only while a result waits.
// The per-word sum update is one 16-bit add with end-around carry in the frame core.
// Reset clears the frame state and empties the input and result registers.
// Depends on bfc_pkg, bfc_byte_if, bfc_result_if, bfc_frame_core, bfc_result_reg.
module bus_frame_checksum_checker
    import bfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bfc_byte_if.sink     byte_in,
    bfc_result_if.source result_out
);

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        start_reg;
    logic        core_go;
    logic        emit;
    logic        res_free;
    bfc_result_t core_result;

    assign core_go       = in_valid_reg && (!emit || res_free);
    assign byte_in.ready = !in_valid_reg || core_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_in.ready)
            in_valid_reg <= byte_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            byte_reg  <= byte_in.frame_byte;
            start_reg <= byte_in.frame_start;
        end
    end

    bfc_frame_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (core_go),
        .item_valid  (in_valid_reg),
        .frame_byte  (byte_reg),
        .frame_start (start_reg),
        .emit        (emit),
        .result      (core_result)
    );

    bfc_result_reg u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (core_go && emit),
        .data       (core_result),
        .free       (res_free),
        .result_out (result_out)
    );

endmodule
